// File: rtl/core/hrfp_pkg.sv
package hrfp_pkg;

  localparam int POSITION_BITS_DEFAULT = 16;

  localparam logic [7:0] CHAR_SPACE    = 8'h20;
  localparam logic [7:0] CHAR_QUESTION = 8'h3F;
  localparam logic [7:0] CHAR_CR       = 8'h0D;
  localparam logic [7:0] CHAR_LF       = 8'h0A;
  localparam logic [7:0] CHAR_COLON    = 8'h3A;

  localparam int MIN_METHOD_LEN = 2;

  localparam logic [2:0] KIND_METHOD  = 3'd0;
  localparam logic [2:0] KIND_URI     = 3'd1;
  localparam logic [2:0] KIND_QUERY   = 3'd2;
  localparam logic [2:0] KIND_VERSION = 3'd3;
  localparam logic [2:0] KIND_KEY     = 3'd4;
  localparam logic [2:0] KIND_VALUE   = 3'd5;

  localparam logic [1:0] VERDICT_PARSING = 2'd0;
  localparam logic [1:0] VERDICT_DONE    = 2'd1;
  localparam logic [1:0] VERDICT_ERROR   = 2'd2;

  typedef enum logic [10:0] {
    S_METHOD   = 11'b000_0000_0001,
    S_URI      = 11'b000_0000_0010,
    S_QUERY    = 11'b000_0000_0100,
    S_VERSION  = 11'b000_0000_1000,
    S_LF       = 11'b000_0001_0000,
    S_CONTINUE = 11'b000_0010_0000,
    S_FINALIZE = 11'b000_0100_0000,
    S_KEY      = 11'b000_1000_0000,
    S_VALUE    = 11'b001_0000_0000,
    S_HEND     = 11'b010_0000_0000,
    S_ERROR    = 11'b100_0000_0000
  } parse_state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       start_request;
  } hrfp_in_t;

  typedef struct packed {
    logic        field_valid;
    logic [2:0]  field_kind;
    logic [15:0] field_start;
    logic [15:0] field_end;
    logic [1:0]  verdict;
  } hrfp_out_t;

endpackage

// File: rtl/core/hrfp_step.sv
module hrfp_step
  import hrfp_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
  input  hrfp_in_t                 beat,
  input  parse_state_t             parse_state,
  input  logic [POSITION_BITS-1:0] byte_position,
  input  logic [POSITION_BITS-1:0] field_open,
  output parse_state_t             parse_state_next,
  output logic [POSITION_BITS-1:0] byte_position_next,
  output logic [POSITION_BITS-1:0] field_open_next,
  output hrfp_out_t                result
);

  localparam int CW = (POSITION_BITS > 16) ? POSITION_BITS : 16;
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  parse_state_t             st;
  logic [POSITION_BITS-1:0] pos;
  logic [POSITION_BITS-1:0] cfs;
  logic [POSITION_BITS-1:0] pos_inc;
  logic [POSITION_BITS-1:0] diff;
  logic                     len_ge1;
  logic                     len_ge2;
  logic [7:0]               c;
  logic                     rep_valid;
  logic [2:0]               rep_kind;
  logic [POSITION_BITS-1:0] rep_start;
  logic [CW-1:0]            ext_start;
  logic [CW-1:0]            ext_end;

  assign st      = beat.start_request ? S_METHOD : parse_state;
  assign pos     = beat.start_request ? '0 : byte_position;
  assign cfs     = beat.start_request ? '0 : field_open;
  assign c       = beat.data_byte;
  assign pos_inc = (pos == POS_MAX) ? pos : pos + 1'b1;
  assign diff    = pos - cfs;
  assign len_ge1 = pos > cfs;
  assign len_ge2 = len_ge1 && (diff >= POSITION_BITS'(MIN_METHOD_LEN));

  always_comb begin
    parse_state_next = st;
    field_open_next  = cfs;
    rep_valid        = 1'b0;
    rep_kind         = KIND_METHOD;
    rep_start        = cfs;
    unique case (st)
      S_METHOD: begin
        if (c == CHAR_SPACE) begin
          rep_valid = 1'b1;
          rep_kind  = KIND_METHOD;
          if (!len_ge2) begin
            parse_state_next = S_ERROR;
          end else begin
            parse_state_next = S_URI;
            field_open_next  = pos_inc;
          end
        end
      end
      S_URI: begin
        if (c == CHAR_SPACE) begin
          rep_valid = 1'b1;
          rep_kind  = KIND_URI;
          if (!len_ge1) begin
            parse_state_next = S_ERROR;
          end else begin
            parse_state_next = S_VERSION;
            field_open_next  = pos_inc;
          end
        end else if (c == CHAR_QUESTION) begin
          parse_state_next = S_QUERY;
          field_open_next  = pos_inc;
        end
      end
      S_QUERY: begin
        if (c == CHAR_SPACE) begin
          rep_valid        = 1'b1;
          rep_kind         = KIND_QUERY;
          parse_state_next = S_VERSION;
          field_open_next  = pos_inc;
        end
      end
      S_VERSION: begin
        if (c == CHAR_CR) begin
          rep_valid        = 1'b1;
          rep_kind         = KIND_VERSION;
          parse_state_next = S_LF;
        end
      end
      S_LF: begin
        parse_state_next = (c == CHAR_LF) ? S_CONTINUE : S_ERROR;
      end
      S_CONTINUE: begin
        if (c == CHAR_CR) begin
          parse_state_next = S_FINALIZE;
        end else if (c == CHAR_COLON) begin
          rep_valid        = 1'b1;
          rep_kind         = KIND_KEY;
          rep_start        = pos;
          parse_state_next = S_ERROR;
          field_open_next  = pos;
        end else begin
          parse_state_next = S_KEY;
          field_open_next  = pos;
        end
      end
      S_FINALIZE: begin
        if (c == CHAR_LF) begin
          parse_state_next = S_KEY;
          field_open_next  = pos_inc;
        end else begin
          parse_state_next = S_ERROR;
        end
      end
      S_KEY: begin
        if (c == CHAR_COLON) begin
          rep_valid = 1'b1;
          rep_kind  = KIND_KEY;
          if (!len_ge1) begin
            parse_state_next = S_ERROR;
          end else begin
            parse_state_next = S_VALUE;
            field_open_next  = pos_inc;
          end
        end
      end
      S_VALUE: begin
        if (c == CHAR_SPACE) begin
          field_open_next = pos_inc;
        end else if (c == CHAR_CR) begin
          rep_valid        = 1'b1;
          rep_kind         = KIND_VALUE;
          rep_start        = pos;
          parse_state_next = S_HEND;
          field_open_next  = pos;
        end else if (c == CHAR_LF) begin
          parse_state_next = S_KEY;
          field_open_next  = pos_inc;
        end else begin
          parse_state_next = S_HEND;
          field_open_next  = pos;
        end
      end
      S_HEND: begin
        if (c == CHAR_CR) begin
          rep_valid = 1'b1;
          rep_kind  = KIND_VALUE;
        end else if (c == CHAR_LF) begin
          parse_state_next = S_KEY;
          field_open_next  = pos_inc;
        end
      end
      default: begin
        parse_state_next = S_ERROR;
      end
    endcase
  end

  assign byte_position_next = pos_inc;

  assign ext_start = CW'(rep_start);
  assign ext_end   = CW'(pos);

  always_comb begin
    result.field_valid = rep_valid;
    result.field_kind  = rep_valid ? rep_kind : KIND_METHOD;
    result.field_start = '0;
    result.field_end   = '0;
    if (rep_valid) begin
      result.field_start = (ext_start > CW'(16'hFFFF)) ? 16'hFFFF : ext_start[15:0];
      result.field_end   = (ext_end > CW'(16'hFFFF)) ? 16'hFFFF : ext_end[15:0];
    end
    priority if (parse_state_next == S_ERROR) begin
      result.verdict = VERDICT_ERROR;
    end else if (beat.last_byte) begin
      result.verdict = (parse_state_next == S_KEY) ? VERDICT_DONE : VERDICT_ERROR;
    end else begin
      result.verdict = VERDICT_PARSING;
    end
  end

endmodule

// File: rtl/core/http_request_field_parser.sv
// channel  | handshake             | payload
// ---------+-----------------------+---------------------------------
// src      | src_valid / src_ready | src_beat : hrfp_in_t (one byte)
// res      | res_valid / res_ready | res_beat : hrfp_out_t (one result)
//
// One byte per cycle with res_ready high; res_valid rises as a byte leaves stage.
// Parse state and positions update when a byte moves from the input register
// into the result register, through one pass of compare and increment logic.
// rst clears both registers' valid flags and returns the parse to the method field.
// A held result stalls the input register; src_ready drops only when both are full.
module http_request_field_parser
  import hrfp_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      src_valid,
  output logic      src_ready,
  input  hrfp_in_t  src_beat,
  output logic      res_valid,
  input  logic      res_ready,
  output hrfp_out_t res_beat
);

  logic                     stage_valid;
  hrfp_in_t                 stage;
  logic                     advance;
  parse_state_t             parse_state;
  parse_state_t             parse_state_next;
  logic [POSITION_BITS-1:0] byte_position;
  logic [POSITION_BITS-1:0] byte_position_next;
  logic [POSITION_BITS-1:0] field_open;
  logic [POSITION_BITS-1:0] field_open_next;
  hrfp_out_t                step_result;

  assign advance   = !res_valid || res_ready;
  assign src_ready = !stage_valid || advance;

  hrfp_step #(
    .POSITION_BITS(POSITION_BITS)
  ) u_step (
    .beat               (stage),
    .parse_state        (parse_state),
    .byte_position      (byte_position),
    .field_open         (field_open),
    .parse_state_next   (parse_state_next),
    .byte_position_next (byte_position_next),
    .field_open_next    (field_open_next),
    .result             (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid   <= 1'b0;
      res_valid     <= 1'b0;
      parse_state   <= S_METHOD;
      byte_position <= '0;
      field_open    <= '0;
    end else begin
      if (src_ready) begin
        stage_valid <= src_valid;
      end
      if (advance) begin
        res_valid <= stage_valid;
      end
      if (advance && stage_valid) begin
        parse_state   <= parse_state_next;
        byte_position <= byte_position_next;
        field_open    <= field_open_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && src_ready) begin
      stage <= src_beat;
    end
    if (advance && stage_valid) begin
      res_beat <= step_result;
    end
  end

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_beat.field_valid) |-> (res_beat.field_kind <= KIND_VALUE))
    else $error("field kind out of range");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_beat.field_valid) |->
      (res_beat.field_kind == KIND_METHOD && res_beat.field_start == '0 &&
       res_beat.field_end == '0))
    else $error("fields not cleared without a located field");

  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_beat.verdict <= VERDICT_ERROR))
    else $error("undefined verdict code");

  a_position_moves: assert property (@(posedge clk) disable iff (rst)
    (advance && stage_valid) |=> (byte_position != '0))
    else $error("byte position did not advance");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !stage_valid |-> src_ready)
    else $error("input stalled with empty input register");

endmodule

// File: tb/testbench.sv
module testbench
  import hrfp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PB = POSITION_BITS_DEFAULT;
  localparam int RANDOM_BYTES = 1150;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      src_valid = 1'b0;
  logic      src_ready;
  hrfp_in_t  src_beat = '0;
  logic      res_valid;
  logic      res_ready = 1'b0;
  hrfp_out_t res_beat;

  http_request_field_parser u_top (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_beat  (src_beat),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_beat  (res_beat)
  );

  always #1 clk = ~clk;

  // parser shadow state
  parse_state_t  fsm = S_METHOD;
  logic [PB-1:0] next_pos = '0;
  logic [PB-1:0] field_open = '0;
  logic          hit;
  logic [2:0]    hit_kind;
  logic [PB-1:0] hit_from;
  logic [PB-1:0] hit_to;

  hrfp_out_t expected_results[$];
  int        mismatches = 0;
  int        live_bytes = 0;
  int        results_checked = 0;
  int        field_counts[6] = '{default: 0};
  int        done_count = 0;
  int        error_count = 0;

  logic pace_on = 1'b0;
  logic stall_on = 1'b0;
  int   burst_left = 0;
  int   ready_run = 0;

  function automatic logic [PB-1:0] bump(logic [PB-1:0] v);
    return (v == {PB{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic logic [15:0] port_pos(logic [PB-1:0] v);
    return (v > 65535) ? 16'hFFFF : 16'(v);
  endfunction

  function automatic logic [PB-1:0] close_field(logic [2:0] kind, logic [PB-1:0] pos);
    hit      = 1'b1;
    hit_kind = kind;
    hit_from = field_open;
    hit_to   = pos;
    return (pos >= field_open) ? pos - field_open : '0;
  endfunction

  function automatic void key_char(logic [7:0] c, logic [PB-1:0] pos);
    if (c == CHAR_COLON) begin
      if (close_field(KIND_KEY, pos) < 1) begin
        fsm = S_ERROR;
      end else begin
        fsm        = S_VALUE;
        field_open = bump(pos);
      end
    end
  endfunction

  function automatic void value_char(logic [7:0] c, logic [PB-1:0] pos);
    if (c == CHAR_CR) begin
      void'(close_field(KIND_VALUE, pos));
    end else if (c == CHAR_LF) begin
      fsm        = S_KEY;
      field_open = bump(pos);
    end
  endfunction

  function automatic hrfp_out_t predict_byte(hrfp_in_t b);
    hrfp_out_t     r;
    logic [7:0]    c;
    logic [PB-1:0] pos;
    r = '0;
    c = b.data_byte;
    if (b.start_request) begin
      fsm        = S_METHOD;
      next_pos   = '0;
      field_open = '0;
    end
    pos = next_pos;
    hit = 1'b0;
    case (fsm)
      S_METHOD: begin
        if (c == CHAR_SPACE) begin
          if (close_field(KIND_METHOD, pos) < MIN_METHOD_LEN) begin
            fsm = S_ERROR;
          end else begin
            fsm        = S_URI;
            field_open = bump(pos);
          end
        end
      end
      S_URI: begin
        if (c == CHAR_SPACE) begin
          if (close_field(KIND_URI, pos) < 1) begin
            fsm = S_ERROR;
          end else begin
            fsm        = S_VERSION;
            field_open = bump(pos);
          end
        end else if (c == CHAR_QUESTION) begin
          fsm        = S_QUERY;
          field_open = bump(pos);
        end
      end
      S_QUERY: begin
        if (c == CHAR_SPACE) begin
          void'(close_field(KIND_QUERY, pos));
          fsm        = S_VERSION;
          field_open = bump(pos);
        end
      end
      S_VERSION: begin
        if (c == CHAR_CR) begin
          void'(close_field(KIND_VERSION, pos));
          fsm = S_LF;
        end
      end
      S_LF: fsm = (c == CHAR_LF) ? S_CONTINUE : S_ERROR;
      S_CONTINUE: begin
        if (c == CHAR_CR) begin
          fsm = S_FINALIZE;
        end else begin
          fsm        = S_KEY;
          field_open = pos;
          key_char(c, pos);
        end
      end
      S_FINALIZE: begin
        if (c == CHAR_LF) begin
          fsm        = S_KEY;
          field_open = bump(pos);
        end else begin
          fsm = S_ERROR;
        end
      end
      S_KEY: key_char(c, pos);
      S_VALUE: begin
        if (c == CHAR_SPACE) begin
          field_open = bump(pos);
        end else begin
          fsm        = S_HEND;
          field_open = pos;
          value_char(c, pos);
        end
      end
      S_HEND: value_char(c, pos);
      default: fsm = S_ERROR;
    endcase
    next_pos = bump(pos);
    if (hit) begin
      r.field_valid = 1'b1;
      r.field_kind  = hit_kind;
      r.field_start = port_pos(hit_from);
      r.field_end   = port_pos(hit_to);
    end
    if (fsm == S_ERROR) r.verdict = VERDICT_ERROR;
    else if (b.last_byte) r.verdict = (fsm == S_KEY) ? VERDICT_DONE : VERDICT_ERROR;
    else r.verdict = VERDICT_PARSING;
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    hrfp_out_t want;
    if (!rst) begin
      if (src_valid && src_ready) begin
        if (src_beat.start_request || fsm != S_ERROR) live_bytes++;
        expected_results.push_back(predict_byte(src_beat));
      end
      if (res_valid && res_ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no expected result pending");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (want.field_valid) field_counts[want.field_kind]++;
          if (want.verdict == VERDICT_DONE) done_count++;
          if (want.verdict == VERDICT_ERROR) error_count++;
          check_field("field_valid", 16'(want.field_valid), 16'(res_beat.field_valid));
          check_field("field_kind", 16'(want.field_kind), 16'(res_beat.field_kind));
          check_field("field_start", want.field_start, res_beat.field_start);
          check_field("field_end", want.field_end, res_beat.field_end);
          check_field("verdict", 16'(want.verdict), 16'(res_beat.verdict));
        end
      end
    end
  end

  // result-side backpressure: alternate ready and stall runs while stall_on, else always ready
  always @(negedge clk) begin
    if (!stall_on) begin
      res_ready <= 1'b1;
    end else if (ready_run == 0) begin
      res_ready <= !res_ready;
      ready_run <= res_ready ? $urandom_range(1, 4) : $urandom_range(1, 12);
    end else begin
      ready_run <= ready_run - 1;
    end
  end

  task automatic send_byte(logic [7:0] d, logic last, logic first);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if (pace_on) begin
        @(negedge clk);
        src_valid <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    src_valid <= 1'b1;
    src_beat  <= '{data_byte: d, last_byte: last, start_request: first};
    do @(posedge clk); while (!src_ready);
  endtask

  task automatic send_text(string s, logic first, logic last);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], last && (i == s.len() - 1), first && (i == 0));
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    src_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  function automatic void add_letters(ref logic [7:0] q[$], input int n);
    for (int i = 0; i < n; i++) q.push_back(8'($urandom_range("A", "z")));
  endfunction

  task automatic test_request_line();
    pace_on  = 1'b1;
    stall_on = 1'b1;
    send_text("GT /?a H\015\012\015\012", 1'b0, 1'b1);
  endtask

  task automatic test_short_method();
    send_text("A /", 1'b1, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b0);
  endtask

  task automatic test_empty_uri();
    send_text("GT  H", 1'b1, 1'b0);
  endtask

  task automatic test_missing_lf();
    send_text("GT / H\015", 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_text("GT / H\015\012\015X", 1'b1, 1'b0);
  endtask

  task automatic test_header_lines();
    send_text("GT / H\015\012K:  v\015w\015\012E: \015\012\015\012", 1'b1, 1'b1);
    send_text("GT / H\015\012:", 1'b1, 1'b0);
    send_text("GT / H\015\012K:v\015\012:", 1'b1, 1'b0);
  endtask

  task automatic test_last_byte_mid_parse();
    send_text("GT", 1'b1, 1'b1);
    send_text(" / H\015\012\015\012", 1'b0, 1'b1);
    send_text("K:v\015\012", 1'b0, 1'b1);
    wait_for_results();
  endtask

  task automatic test_random_requests();
    logic [7:0] req[$];
    int         base;
    int         n;
    logic       first;
    base = live_bytes;
    while (live_bytes - base < RANDOM_BYTES) begin
      req.delete();
      pace_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0) wait_for_results();
      add_letters(req, ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 6));
      req.push_back(CHAR_SPACE);
      if ($urandom_range(0, 11) != 0) begin
        req.push_back("/");
        add_letters(req, $urandom_range(0, 6));
      end
      if ($urandom_range(0, 2) == 0) begin
        req.push_back(CHAR_QUESTION);
        add_letters(req, $urandom_range(0, 5));
        if ($urandom_range(0, 3) == 0) req.push_back(CHAR_QUESTION);
      end
      req.push_back(CHAR_SPACE);
      add_letters(req, $urandom_range(1, 8));
      req.push_back(CHAR_CR);
      req.push_back(CHAR_LF);
      repeat ($urandom_range(0, 3)) begin
        if ($urandom_range(0, 11) != 0) add_letters(req, $urandom_range(1, 6));
        req.push_back(CHAR_COLON);
        repeat ($urandom_range(0, 2)) req.push_back(CHAR_SPACE);
        add_letters(req, $urandom_range(0, 5));
        req.push_back(CHAR_CR);
        if ($urandom_range(0, 5) == 0) begin
          add_letters(req, $urandom_range(1, 3));
          req.push_back(CHAR_CR);
        end
        req.push_back(CHAR_LF);
      end
      req.push_back(CHAR_CR);
      req.push_back(CHAR_LF);
      // corrupt or truncate some requests
      if ($urandom_range(0, 3) == 0)
        req[$urandom_range(0, req.size() - 1)] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, req.size());
        while (req.size() > n) void'(req.pop_back());
      end
      first = ($urandom_range(0, 9) != 0);
      foreach (req[i])
        send_byte(req[i], (i == req.size() - 1) || ($urandom_range(0, 39) == 0),
                  first && (i == 0));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_request_line();
    test_short_method();
    test_empty_uri();
    test_missing_lf();
    test_header_lines();
    test_last_byte_mid_parse();
    test_random_requests();
    wait_for_results();
    repeat (8) @(posedge clk);
    $display("Checked %0d result beats: %0d done and %0d error verdicts.",
             results_checked, done_count, error_count);
    $display("Fields located: method %0d, uri %0d, query %0d, version %0d, key %0d, value %0d.",
             field_counts[KIND_METHOD], field_counts[KIND_URI], field_counts[KIND_QUERY],
             field_counts[KIND_VERSION], field_counts[KIND_KEY], field_counts[KIND_VALUE]);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout: %0d expected results still pending", expected_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
